// File: src/ppr_pkg.sv
`default_nettype none

package ppr_pkg;

    // Row codes carried in the second header byte
    localparam logic [7:0] ROW_CODE_END      = 8'h80;
    localparam logic [7:0] ROW_CODE_EMPTY    = 8'h00;
    localparam logic [7:0] ROW_CODE_MASK_MAX = 8'h0F;

    localparam int unsigned NUM_CHANNELS = 4;
    localparam int unsigned EVENT_BITS   = 32;

    // Parse phase of the front end
    typedef enum logic [1:0] {
        PH_HDR1   = 2'd0,
        PH_CODE   = 2'd1,
        PH_EVENTS = 2'd2
    } t_phase;

    typedef logic [NUM_CHANNELS-1:0][EVENT_BITS-1:0] t_words;

    // Command from front to back: one row of words, or zero fill to pattern end
    typedef struct packed {
        logic   fill;
        t_words words;
    } t_cmd;

    // Finished row as handed to the output queue
    typedef struct packed {
        logic [5:0] row_index;
        t_words     words;
        logic       last_row;
    } t_row;

    // Number of set bits in a channel mask
    function automatic logic [2:0] mask_count(input logic [3:0] m);
        mask_count = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
    endfunction

    // Channel holding the n-th event of the mask, 0 if none
    function automatic logic [1:0] nth_channel(input logic [3:0] m, input logic [1:0] n);
        logic [2:0] seen;
        logic [1:0] ch;
        seen = 3'd0;
        ch   = 2'd0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
            if (m[c]) begin
                seen = seen + 3'd1;
            end
        end
        seen = 3'd0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (m[c]) begin
                if (seen == {1'b0, n}) begin
                    ch = 2'(c);
                end
                seen = seen + 3'd1;
            end
        end
        nth_channel = ch;
    endfunction

endpackage

`default_nettype wire

// File: src/ppr_fifo.sv
`default_nettype none

module ppr_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_entries [DEPTH];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;
    logic             wr_en;
    logic             rd_en;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                     (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_entries[r_rd_ptr[AW-1:0]];

    // Pointers carry a wrap bit to tell full from empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_entries[r_wr_ptr[AW-1:0]] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: src/ppr_front.sv
`default_nettype none

module ppr_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output logic            o_cmd_push,
    output ppr_pkg::t_cmd   o_cmd
);

    ppr_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_mask, n_mask;
    logic [3:0]      r_cnt, n_cnt;
    ppr_pkg::t_words r_buf, n_buf;

    logic [1:0] ch;
    logic [4:0] total;
    logic [4:0] cnt_inc;

    assign ch      = ppr_pkg::nth_channel(r_mask, r_cnt[3:2]);
    assign total   = {ppr_pkg::mask_count(r_mask), 2'b00};
    assign cnt_inc = {1'b0, r_cnt} + 5'd1;

    // Phase register and row assembly state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ppr_pkg::PH_HDR1;
            r_mask  <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_mask  <= n_mask;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    // Classify each byte and issue a command when a row is complete
    always_comb begin
        n_phase    = r_phase;
        n_mask     = r_mask;
        n_cnt      = r_cnt;
        n_buf      = r_buf;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (i_valid) begin
            case (r_phase)
                ppr_pkg::PH_CODE: begin
                    if (i_byte == ppr_pkg::ROW_CODE_END) begin
                        o_cmd.fill = 1'b1;
                        o_cmd_push = 1'b1;
                        n_phase    = ppr_pkg::PH_HDR1;
                    end else if (i_byte == ppr_pkg::ROW_CODE_EMPTY ||
                                 i_byte > ppr_pkg::ROW_CODE_MASK_MAX) begin
                        o_cmd_push = 1'b1;
                        n_phase    = ppr_pkg::PH_HDR1;
                    end else begin
                        n_mask  = i_byte[3:0];
                        n_cnt   = '0;
                        n_buf   = '0;
                        n_phase = ppr_pkg::PH_EVENTS;
                    end
                end
                ppr_pkg::PH_EVENTS: begin
                    n_buf[ch] = {r_buf[ch][23:0], i_byte};
                    if (cnt_inc >= total) begin
                        o_cmd.words = n_buf;
                        o_cmd_push  = 1'b1;
                        n_cnt       = '0;
                        n_phase     = ppr_pkg::PH_HDR1;
                    end else begin
                        n_cnt = cnt_inc[3:0];
                    end
                end
                default: begin
                    // first header byte, or the unused phase code
                    n_phase = ppr_pkg::PH_CODE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/ppr_back.sv
`default_nettype none

module ppr_back #(
    parameter int unsigned ROWS_PER_PATTERN = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_empty,
    input  wire ppr_pkg::t_cmd  i_cmd,
    output logic                o_cmd_pop,
    input  wire logic           i_row_full,
    output logic                o_row_push,
    output ppr_pkg::t_row       o_row
);

    localparam int unsigned CW = (ROWS_PER_PATTERN > 1) ? $clog2(ROWS_PER_PATTERN) : 1;
    localparam logic [CW-1:0] LAST_ROW = CW'(ROWS_PER_PATTERN - 1);

    logic [CW-1:0] r_row, n_row;
    logic          go;
    logic          last;

    assign go   = !i_cmd_empty && !i_row_full;
    assign last = (r_row == LAST_ROW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    // One row per cycle while go; a fill command heads until the last row
    always_comb begin
        o_row.row_index = 6'(r_row);
        o_row.words     = i_cmd.fill ? '0 : i_cmd.words;
        o_row.last_row  = last;
        o_row_push      = go;
        o_cmd_pop       = go && (!i_cmd.fill || last);
        n_row           = r_row;
        if (go) begin
            n_row = last ? '0 : r_row + 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: src/packed_pattern_row_decoder.sv
// Packed pattern row decoder.
// Input queue side: drive i_data_byte and push; a byte is taken on each
// clock edge with push high and full low; one byte per cycle is sustained
// while full stays low. Result queue side: while empty is low the oldest
// row is on the o_ ports; pop with empty low takes it. Each row carries
// its index, four channel event words (zero where absent) and o_last_row
// on the final pattern row.
// The front end parses bytes and writes one command per row (or one zero
// fill command for an end marker) into a two-entry command queue; the
// back end turns commands into rows, one row per cycle while the result
// queue has room, into a two-entry result queue. An end marker thus yields
// ROWS_PER_PATTERN - row zero rows, during which further bytes still enter
// until the command queue fills.
// When the receiver stalls, the result queue fills, the back end holds,
// the command queue fills and full rises; nothing is lost.
// Reset (synchronous, i_rst_n low) empties both queues, sets the parser to
// expect a first header byte and the row counter to zero.
`default_nettype none

module packed_pattern_row_decoder #(
    parameter int unsigned ROWS_PER_PATTERN = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [5:0]       o_row_index,
    output logic [31:0]      o_chan0_event,
    output logic [31:0]      o_chan1_event,
    output logic [31:0]      o_chan2_event,
    output logic [31:0]      o_chan3_event,
    output logic             o_last_row
);

    logic          cmd_push;
    ppr_pkg::t_cmd cmd_in;
    logic          cmd_full;
    logic          cmd_empty;
    logic          cmd_pop;
    ppr_pkg::t_cmd cmd_head;
    logic          row_push;
    ppr_pkg::t_row row_in;
    logic          row_full;
    ppr_pkg::t_row row_head;

    assign full = cmd_full;

    // Front end: byte parsing and row assembly
    ppr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push && !cmd_full),
        .i_byte     (i_data_byte),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // Command queue between front and back
    ppr_fifo #(
        .WIDTH ($bits(ppr_pkg::t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_head)
    );

    // Back end: row numbering and zero fill
    ppr_back #(
        .ROWS_PER_PATTERN (ROWS_PER_PATTERN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_row_full  (row_full),
        .o_row_push  (row_push),
        .o_row       (row_in)
    );

    // Result queue
    ppr_fifo #(
        .WIDTH ($bits(ppr_pkg::t_row)),
        .DEPTH (2)
    ) u_row_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (row_push),
        .i_data  (row_in),
        .o_full  (row_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (row_head)
    );

    assign o_row_index   = row_head.row_index;
    assign o_chan0_event = row_head.words[0];
    assign o_chan1_event = row_head.words[1];
    assign o_chan2_event = row_head.words[2];
    assign o_chan3_event = row_head.words[3];
    assign o_last_row    = row_head.last_row;

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;

    localparam int ROWS       = 64;
    localparam int ITEMS      = 260;
    localparam int HOLD_LEN   = 300;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 20;

    // One finished row as seen on the result side
    typedef struct packed {
        logic [5:0]  row_index;
        logic [31:0] chan0;
        logic [31:0] chan1;
        logic [31:0] chan2;
        logic [31:0] chan3;
        logic        last_row;
    } row_t;

    // Row rebuilder: tracks the parser and keeps the rows still owed by the block
    class row_scoreboard;
        ppr_pkg::t_phase phase;
        int unsigned     row_ctr;
        logic [3:0]      mask;
        int unsigned     ev_count;
        logic [31:0]     words [4];
        row_t            rows_due [$];
        int              errors;

        function new();
            phase    = ppr_pkg::PH_HDR1;
            row_ctr  = 0;
            mask     = '0;
            ev_count = 0;
            foreach (words[c]) words[c] = '0;
            errors   = 0;
        endfunction

        // Queue one row and advance the row counter, wrapping at pattern end
        function void emit_row(bit zero_row);
            row_t r;
            r.row_index = row_ctr[5:0];
            r.chan0     = zero_row ? 32'h0 : words[0];
            r.chan1     = zero_row ? 32'h0 : words[1];
            r.chan2     = zero_row ? 32'h0 : words[2];
            r.chan3     = zero_row ? 32'h0 : words[3];
            r.last_row  = (row_ctr + 1 >= ROWS);
            rows_due.push_back(r);
            row_ctr = r.last_row ? 0 : row_ctr + 1;
        endfunction

        // Accepted input transaction
        function void note_byte(logic [7:0] b);
            bit          done;
            int unsigned slot;
            int unsigned seen;
            int unsigned ch;
            case (phase)
                ppr_pkg::PH_CODE: begin
                    if (b == ppr_pkg::ROW_CODE_END) begin
                        // zero rows up to and including the last pattern row
                        do begin
                            done = (row_ctr + 1 >= ROWS);
                            emit_row(1'b1);
                        end while (!done);
                        phase = ppr_pkg::PH_HDR1;
                    end else if (b == ppr_pkg::ROW_CODE_EMPTY ||
                                 b > ppr_pkg::ROW_CODE_MASK_MAX) begin
                        emit_row(1'b1);
                        phase = ppr_pkg::PH_HDR1;
                    end else begin
                        mask     = b[3:0];
                        ev_count = 0;
                        foreach (words[c]) words[c] = '0;
                        phase    = ppr_pkg::PH_EVENTS;
                    end
                end
                ppr_pkg::PH_EVENTS: begin
                    // event bytes fill channels in ascending order, four each
                    slot = (ev_count >> 2) & 3;
                    seen = 0;
                    ch   = 0;
                    for (int c = 0; c < 4; c++) begin
                        if (mask[c]) begin
                            if (seen == slot) ch = c;
                            seen++;
                        end
                    end
                    words[ch] = {words[ch][23:0], b};
                    if (ev_count + 1 >= 4 * $countones(mask)) begin
                        emit_row(1'b0);
                        ev_count = 0;
                        phase    = ppr_pkg::PH_HDR1;
                    end else begin
                        ev_count = (ev_count + 1) & 15;
                    end
                end
                default: phase = ppr_pkg::PH_CODE;
            endcase
        endfunction

        // Accepted result transaction
        function void check_row(row_t got);
            row_t want;
            if (rows_due.size() == 0) begin
                $error("unexpected row: row_index %0d", got.row_index);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            if (got.row_index !== want.row_index) begin
                $error("row_index: expected %0d, actual %0d", want.row_index, got.row_index);
                errors++;
            end
            if (got.chan0 !== want.chan0) begin
                $error("chan0_event: expected %h, actual %h", want.chan0, got.chan0);
                errors++;
            end
            if (got.chan1 !== want.chan1) begin
                $error("chan1_event: expected %h, actual %h", want.chan1, got.chan1);
                errors++;
            end
            if (got.chan2 !== want.chan2) begin
                $error("chan2_event: expected %h, actual %h", want.chan2, got.chan2);
                errors++;
            end
            if (got.chan3 !== want.chan3) begin
                $error("chan3_event: expected %h, actual %h", want.chan3, got.chan3);
                errors++;
            end
            if (got.last_row !== want.last_row) begin
                $error("last_row: expected %0d, actual %0d", want.last_row, got.last_row);
                errors++;
            end
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function bit at_row_start();
            return phase == ppr_pkg::PH_HDR1;
        endfunction

        function int next_row();
            return row_ctr;
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        full;
    logic        empty;
    logic [5:0]  o_row_index;
    logic [31:0] o_chan0_event;
    logic [31:0] o_chan1_event;
    logic [31:0] o_chan2_event;
    logic [31:0] o_chan3_event;
    logic        o_last_row;

    row_scoreboard sb = new();
    int  sent     = 0;
    int  cycles   = 0;
    bit  no_idle  = 1'b0;
    bit  hold_req = 1'b0;

    packed_pattern_row_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_row_index   (o_row_index),
        .o_chan0_event (o_chan0_event),
        .o_chan1_event (o_chan1_event),
        .o_chan2_event (o_chan2_event),
        .o_chan3_event (o_chan3_event),
        .o_last_row    (o_last_row)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check every popped row
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_row('{row_index: o_row_index, chan0: o_chan0_event,
                           chan1: o_chan1_event, chan2: o_chan2_event,
                           chan3: o_chan3_event, last_row: o_last_row});
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("[packed_pattern_row_decoder] ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold on request
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one byte, optionally after an idle burst, and wait for the transaction
    task automatic send_byte(input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 6) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        sb.note_byte(b);
        sent++;
    endtask

    function automatic logic [7:0] event_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Header byte, channel mask and the events it announces
    task automatic send_event_row(input logic [3:0] m);
        send_byte(8'($urandom_range(0, 255)));
        send_byte({4'h0, m});
        repeat (4 * $countones(m)) send_byte(event_byte());
    endtask

    // Header byte followed by an empty-row code
    task automatic send_empty_row();
        logic [7:0] code;
        if ($urandom_range(0, 1) == 0) begin
            code = ppr_pkg::ROW_CODE_EMPTY;
        end else begin
            do code = 8'($urandom_range(16, 255)); while (code == ppr_pkg::ROW_CODE_END);
        end
        send_byte(8'($urandom_range(0, 255)));
        send_byte(code);
    endtask

    task automatic send_end_marker();
        send_byte(8'($urandom_range(0, 255)));
        send_byte(ppr_pkg::ROW_CODE_END);
    endtask

    // Get back to a row header, then fill empty rows up to the last one
    task automatic run_to_pattern_end();
        while (!sb.at_row_start()) send_byte(8'($urandom_range(0, 255)));
        while (sb.next_row() != ROWS - 1) send_empty_row();
        if ($urandom_range(0, 1) == 0) send_end_marker();
        else send_event_row(4'($urandom_range(1, 15)));
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        bit sprint_done;
        int pick;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        sprint_done = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: end marker on row 0 gives a whole pattern of zero rows
        send_byte(8'h00);
        send_byte(ppr_pkg::ROW_CODE_END);
        // all four channels with extreme event words
        send_byte(8'hFF);
        send_byte(8'h0F);
        send_byte(8'h80); send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h78);
        // empty rows: zero code and the first code above the mask range
        send_byte(8'h5A);
        send_byte(ppr_pkg::ROW_CODE_EMPTY);
        send_byte(8'hA5);
        send_byte(8'h10);
        // top channel alone
        send_byte(8'h3C);
        send_byte(8'h08);
        send_byte(8'hDE); send_byte(8'hAD); send_byte(8'hBE); send_byte(8'hEF);

        // Random: mostly well-formed rows, some end markers and stray bytes
        while (!(sprint_done && sent >= ITEMS)) begin
            if (!hold_done && sent >= 140) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent >= 200) begin
                push <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end
            if (sprint_done && sent >= ITEMS - 40) no_idle = 1'b1;

            if (!sprint_done && sent >= 60) begin
                run_to_pattern_end();
                sprint_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8) repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                else if (pick < 12) send_end_marker();
                else if (pick < 40) send_empty_row();
                else send_event_row(4'($urandom_range(1, 15)));
            end
        end
        push <= 1'b0;

        // Drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[packed_pattern_row_decoder] OK");
        end else begin
            $display("[packed_pattern_row_decoder] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: packed_pattern_row_decoder.f
src/ppr_pkg.sv
src/ppr_fifo.sv
src/ppr_front.sv
src/ppr_back.sv
src/packed_pattern_row_decoder.sv
tb/tb.sv
